>>> design/moving_average_with_warmup_assert.svh
// Assertion macros shared by the moving average block.
`ifndef MOVING_AVERAGE_WITH_WARMUP_ASSERT_SVH
`define MOVING_AVERAGE_WITH_WARMUP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MAVG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MAVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average assertion failed");

`endif

>>> design/mavg_pkg.sv
`default_nettype none

package mavg_pkg;

    // Width of a converter sample and of an average.
    localparam int SAMPLE_W = 24;

    // Default averaging window.
    localparam int WINDOW_DEFAULT = 50;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the sample, read the oldest ring entry
        logic update;    // update the sum, store the sample, move the pointer
        logic prep;      // load the divider with the sum magnitude
        logic step;      // one quotient bit
        logic load_out;  // write the signed quotient into the output register
    } mavg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;  // the divider is on its final step
    } mavg_status_t;

endpackage

`default_nettype wire

>>> design/mavg_ram.sv
`default_nettype none

module mavg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 50
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/mavg_datapath.sv
`default_nettype none

module mavg_datapath #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mavg_pkg::mavg_cmd_t                  cmd,
    output mavg_pkg::mavg_status_t                    status,
    input  wire logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
    output logic signed      [mavg_pkg::SAMPLE_W-1:0] average
);

    import mavg_pkg::*;

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SUM_W-1:0]    sum_reg,   sum_next;
    logic [PTR_W-1:0]           ptr_reg,   ptr_next;
    logic                       full_reg,  full_next;
    logic [SUM_W-1:0]           quo_reg,   quo_next;
    logic [CNT_W-1:0]           rem_reg,   rem_next;
    logic [STEP_W-1:0]          step_reg,  step_next;
    logic                       neg_reg,   neg_next;
    logic signed [SAMPLE_W-1:0] avg_reg,   avg_next;

    logic signed [SAMPLE_W-1:0] oldest;
    logic signed [SUM_W-1:0]    drop;
    logic [CNT_W-1:0]           divisor;
    logic [CNT_W:0]             trial;
    logic [CNT_W-1:0]           diff;
    logic [SAMPLE_W-1:0]        quo_low;

    mavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (ptr_reg),
        .wdata (x_reg),
        .re    (cmd.accept),
        .raddr (ptr_reg),
        .rdata (oldest)
    );

    // The divisor follows the updated pointer: samples stored so far, or the window.
    assign divisor = full_reg ? CNT_W'(WINDOW) : CNT_W'(ptr_reg);
    assign trial   = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = trial[CNT_W-1:0] - divisor;
    assign quo_low = quo_reg[SAMPLE_W-1:0];
    assign drop    = full_reg ? SUM_W'(oldest) : '0;

    always_comb
    begin
        sum_next  = sum_reg;
        ptr_next  = ptr_reg;
        full_next = full_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        avg_next  = avg_reg;

        if (cmd.update)
        begin
            sum_next = sum_reg - drop + SUM_W'(x_reg);
            if (ptr_reg == PTR_W'(WINDOW - 1))
            begin
                ptr_next  = '0;
                full_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end

        if (cmd.prep)
        begin
            neg_next  = sum_reg[SUM_W-1];
            quo_next  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            rem_next  = '0;
            step_next = STEP_W'(SUM_W);
        end

        if (cmd.step)
        begin
            step_next = step_reg - STEP_W'(1);
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff;
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end

        if (cmd.load_out)
        begin
            avg_next = neg_reg ? SAMPLE_W'(-quo_low) : SAMPLE_W'(quo_low);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            ptr_reg  <= '0;
            full_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            ptr_reg  <= ptr_next;
            full_reg <= full_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= sample;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        avg_reg <= avg_next;
    end

    assign status.div_last = (step_reg == STEP_W'(1));
    assign average         = avg_reg;

endmodule

`default_nettype wire

>>> design/mavg_ctrl.sv
`default_nettype none

`include "moving_average_with_warmup_assert.svh"

module mavg_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    output logic                        average_valid,
    input  wire logic                   average_ready,
    output mavg_pkg::mavg_cmd_t         cmd,
    input  wire mavg_pkg::mavg_status_t status
);

    import mavg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       avg_valid_reg, avg_valid_next;
    logic       out_free;

    assign out_free = !avg_valid_reg || average_ready;

    always_comb
    begin
        state_next     = state_reg;
        avg_valid_next = avg_valid_reg;
        cmd            = '0;
        sample_ready   = 1'b0;

        if (avg_valid_reg && average_ready)
        begin
            avg_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    avg_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    assign average_valid = avg_valid_reg;

    // A taken sample always moves straight on to the sum update.
    `MAVG_ASSERT_NEXT(a_accept_to_update, sample_valid && sample_ready, state_reg == ST_UPDATE)
    // A new average never overwrites one that has not been delivered.
    `MAVG_ASSERT_SAME(a_no_overwrite, cmd.load_out, !avg_valid_reg || average_ready)
    // The output only becomes valid through a load of the output register.
    `MAVG_ASSERT_SAME(a_valid_from_load, $rose(avg_valid_reg), $past(cmd.load_out))

endmodule

`default_nettype wire

>>> design/moving_average_with_warmup.sv
// Boxcar moving average with warm-up. Each request carries one signed 24-bit converter
// sample and produces exactly one signed 24-bit average: the sum of the last WINDOW
// samples divided by WINDOW, or, while fewer than WINDOW samples have arrived since
// reset, the sum of all samples so far divided by their count. The quotient truncates
// toward zero. The samples live in a WINDOW-entry ring RAM next to a running sum,
// so each request costs one RAM read and one write. The block takes one request at a
// time: it is ready again only after the restoring divider has run over the full
// running-sum width SUM_W = 24 + clog2(WINDOW), one quotient bit per cycle, and the
// quotient has been loaded into the output register. The average sits in an output
// register, so the next request is accepted while the previous average still waits
// to be taken; only a second finished average waits for the first to leave.
`default_nettype none

module moving_average_with_warmup #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    input  wire logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
    output logic                                      average_valid,
    input  wire logic                                 average_ready,
    output logic signed      [mavg_pkg::SAMPLE_W-1:0] average
);

    import mavg_pkg::*;

    // Commands flow from the sequencer into the datapath; the datapath only
    // reports when the divider reaches its last bit.
    mavg_cmd_t    cmd;
    mavg_status_t status;

    // The controller owns the handshakes and the output valid flag.
    mavg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .average_valid (average_valid),
        .average_ready (average_ready),
        .cmd           (cmd),
        .status        (status)
    );

    // The datapath holds the ring RAM, the running sum, the write pointer,
    // the full flag, the serial divider and the output register.
    mavg_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .sample  (sample),
        .average (average)
    );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the boxcar moving average. Every request carries one signed sample
// and yields exactly one average, so the checker keeps a queue of predicted
// averages in request order and compares each average that leaves the block
// against the oldest entry.
module tb_top;

    import mavg_pkg::*;

    localparam int WIN = WINDOW_DEFAULT;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN = 24'sh800000;

    // Shapes of the random stream. Long runs of one extreme drive the running sum
    // to its largest magnitude once the ring has filled, and the swing pattern makes
    // the subtraction of the oldest sample move the sum by the full range.
    localparam int PAT_MIXED  = 0;
    localparam int PAT_TOP    = 1;
    localparam int PAT_BOTTOM = 2;
    localparam int PAT_SWING  = 3;

    // Number of random requests in each of the four idling phases.
    localparam int PHASE_REQUESTS = 108;

    // One row of the directed table. Where the average is plain to see, it is typed
    // into the row; otherwise the predictor supplies it.
    typedef struct {
        sample_t value;
        bit      known;
        sample_t mean;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_ready;
    sample_t sample;
    logic    average_valid;
    logic    average_ready;
    sample_t average;

    // Predictor state: a copy of the sample ring, the slot to write next, the flag
    // that tells whether the ring has wrapped, and the running sum, held wide.
    sample_t ring_mem [WIN];
    int      wr_idx;
    bit      ring_filled;
    longint  run_sum;

    // Predicted averages, oldest first.
    sample_t mean_fifo [$];

    int err_count      = 0;
    int requests_sent  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Directed requests, issued right after reset. The first sample comes back
    // unchanged. The second shows truncation toward zero: the sum of the two
    // extremes is -1, and -1 / 2 gives 0, not -1. The rows after it keep the warm-up
    // sum slightly negative so that the divide by 3, 4 and 5 also rounds to zero.
    stim_row_t directed_rows [0:20] = '{
        '{SAMPLE_MAX,     1'b1, SAMPLE_MAX},
        '{SAMPLE_MIN,     1'b1, 24'sd0},
        '{-24'sd1,        1'b1, 24'sd0},
        '{-24'sd1,        1'b1, 24'sd0},
        '{24'sd0,         1'b1, 24'sd0},
        '{-24'sd3,        1'b1, -24'sd1},
        '{24'sd1,         1'b0, 24'sd0},
        '{24'sh555555,    1'b0, 24'sd0},
        '{24'shAAAAAA,    1'b0, 24'sd0},
        '{24'sh000001,    1'b0, 24'sd0},
        '{24'shFFFFFE,    1'b0, 24'sd0},
        '{SAMPLE_MAX,     1'b0, 24'sd0},
        '{SAMPLE_MAX,     1'b0, 24'sd0},
        '{SAMPLE_MAX,     1'b0, 24'sd0},
        '{SAMPLE_MIN,     1'b0, 24'sd0},
        '{SAMPLE_MIN,     1'b0, 24'sd0},
        '{SAMPLE_MIN,     1'b0, 24'sd0},
        '{24'sh0F0F0F,    1'b0, 24'sd0},
        '{24'shF0F0F0,    1'b0, 24'sd0},
        '{24'sh123456,    1'b0, 24'sd0},
        '{24'shEDCBA9,    1'b0, 24'sd0}
    };

    moving_average_with_warmup #(
        .WINDOW(WIN)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .average_valid(average_valid),
        .average_ready(average_ready),
        .average      (average)
    );

    always #2 clk = ~clk;

    // Advances the predictor by one sample and returns the average it should give.
    // Once the ring has wrapped, the slot about to be overwritten holds the oldest
    // sample, which leaves the sum first. During warm-up the divisor is the number of
    // samples stored so far, which equals the advanced write index.
    function automatic sample_t next_mean(input sample_t value);
        longint divisor;
        longint quotient;
        if (ring_filled)
        begin
            run_sum -= ring_mem[wr_idx];
        end
        run_sum += value;
        ring_mem[wr_idx] = value;
        wr_idx = (wr_idx == WIN - 1) ? 0 : wr_idx + 1;
        if (wr_idx == 0)
        begin
            ring_filled = 1'b1;
        end
        divisor = ring_filled ? WIN : wr_idx;
        // Signed integer division truncates toward zero, as the block must.
        quotient = run_sum / divisor;
        return quotient[SAMPLE_W-1:0];
    endfunction

    // Offers one request and returns once it has been accepted. The caller is always
    // just past a rising edge, so sample_valid receives a single assignment in this
    // time step: low while the sender idles, or high with the new sample. A request
    // that follows straight on keeps valid high without a dip.
    task automatic offer_sample(input sample_t value, input bit known, input sample_t mean);
        sample_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (!sample_ready)
        begin
            @(posedge clk);
        end
        // The request was taken at this edge; the predictor always runs so that its
        // state follows the block, even where the row carries a typed average.
        predicted = next_mean(value);
        mean_fifo.push_back(known ? mean : predicted);
        requests_sent++;
    endtask

    // Stimulus: reset, the directed table, then four phases of random requests with
    // different idling on each side, and finally the drain.
    initial
    begin
        int      ph;
        int      n;
        int      run_left;
        int      pattern;
        int      small_val;
        sample_t value;

        rst_n         <= 1'b0;
        sample_valid  <= 1'b0;
        sample        <= '0;
        average_ready <= 1'b0;
        wr_idx      = 0;
        ring_filled = 1'b0;
        run_sum     = 0;
        run_left    = 0;
        pattern     = PAT_MIXED;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < $size(directed_rows); n++)
        begin
            offer_sample(directed_rows[n].value, directed_rows[n].known,
                         directed_rows[n].mean);
        end

        // Phase 0 runs with no idling, which is also where the receiver takes its long
        // pause; phase 1 idles the sender, phase 2 stalls the receiver, phase 3 both.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (run_left == 0)
                begin
                    pattern  = $urandom_range(PAT_SWING, PAT_MIXED);
                    run_left = $urandom_range(60, 10);
                end
                run_left--;
                case (pattern)
                    PAT_TOP:    value = SAMPLE_MAX;
                    PAT_BOTTOM: value = SAMPLE_MIN;
                    PAT_SWING:  value = n[0] ? SAMPLE_MAX : SAMPLE_MIN;
                    default:
                    begin
                        // Mostly the full range, with the extremes and values near
                        // zero mixed in.
                        case ($urandom_range(9))
                            0:       value = SAMPLE_MAX;
                            1:       value = SAMPLE_MIN;
                            2, 3:
                            begin
                                small_val = $urandom_range(8);
                                value     = sample_t'(small_val - 4);
                            end
                            default: value = sample_t'($urandom());
                        endcase
                    end
                endcase
                offer_sample(value, 1'b0, '0);
            end
        end
        sample_valid <= 1'b0;

        // Wait for every predicted average, then give the block time to show any
        // stray result before the verdict. The timeout below bounds this wait.
        while (mean_fifo.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        if (err_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: checks each average accepted at an edge and then sets the ready
    // level for the next cycle. Once enough requests have gone in during the phase
    // without idling, the receiver holds off for a long stretch so that the output
    // register and the divider both fill and the block stops taking requests.
    initial
    begin
        int      hold_left;
        bit      hold_done;
        sample_t want;

        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (average_valid && average_ready)
            begin
                if (mean_fifo.size() == 0)
                begin
                    $display("%0t: average with no request pending: expected none, got %0d",
                             $time, average);
                    err_count++;
                end
                else
                begin
                    want = mean_fifo.pop_front();
                    if (average !== want)
                    begin
                        $display("%0t: average mismatch: expected %0d, got %0d",
                                 $time, want, average);
                        err_count++;
                    end
                end
            end
            if (!hold_done && requests_sent >= 60)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                average_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                average_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // This timeout ends a hung run.
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
